// ===== sv/bblgc_pkg.sv =====
package bblgc_pkg;

   localparam int ENTRIES_DEF = 32;
   localparam int FONTS_DEF   = 16;

   localparam int FONT_W  = 4;
   localparam int CHAR_W  = 16;
   localparam int SIZE_W  = 17;
   localparam int BYTES_W = 22;
   localparam int SLOT_W  = 5;

   localparam logic [BYTES_W-1:0] BYTES_MAX    = {BYTES_W{1'b1}};
   localparam logic [BYTES_W-1:0] BUDGET_RESET = BYTES_W'(65536);

   localparam logic [1:0] REQ_LOOKUP    = 2'd0;
   localparam logic [1:0] REQ_INSERT    = 2'd1;
   localparam logic [1:0] REQ_CLEAR_FNT = 2'd2;
   localparam logic [1:0] REQ_CLEAR_ALL = 2'd3;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [FONT_W-1:0] font_id;
      logic [CHAR_W-1:0] char_code;
      logic [SIZE_W-1:0] item_size;
   } req_beat_type;

   typedef struct packed {
      logic               hit;
      logic [SLOT_W-1:0]  slot;
      logic               evicted;
      logic [FONT_W-1:0]  evicted_font;
      logic [CHAR_W-1:0]  evicted_char;
      logic [BYTES_W-1:0] used_bytes;
      logic               last;
   } rsp_beat_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_EVICT,
      ST_CLR_FONT
   } ctl_state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LATCH,
      OP_TOUCH,
      OP_MISS,
      OP_DROP_DUP,
      OP_DROP_OLD,
      OP_DROP_FONT,
      OP_PLACE,
      OP_CLEAR_ALL
   } dp_op_type;

   typedef struct packed {
      logic [1:0] req_code;
      logic       out_free;
      logic       font_ok;
      logic       hit_found;
      logic       free_found;
      logic       any_valid;
      logic       over_budget;
      logic       font_found;
   } dp_status_type;

endpackage

// ===== sv/bblgc_ctrl.sv =====
module bblgc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  bblgc_pkg::dp_status_type status,
   output bblgc_pkg::dp_op_type     op
);

   bblgc_pkg::ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bblgc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bblgc_pkg::ST_IDLE: begin
            if (req_valid) state_in = bblgc_pkg::ST_DECODE;
         end
         bblgc_pkg::ST_DECODE: begin
            if (status.out_free) begin
               case (status.req_code)
                  bblgc_pkg::REQ_INSERT:
                     state_in = status.font_ok ? bblgc_pkg::ST_EVICT : bblgc_pkg::ST_IDLE;
                  bblgc_pkg::REQ_CLEAR_FNT: state_in = bblgc_pkg::ST_CLR_FONT;
                  default: state_in = bblgc_pkg::ST_IDLE;
               endcase
            end
         end
         bblgc_pkg::ST_EVICT: begin
            if (status.out_free &&
                !((!status.free_found || status.over_budget) && status.any_valid))
               state_in = bblgc_pkg::ST_IDLE;
         end
         bblgc_pkg::ST_CLR_FONT: begin
            if (!(status.font_ok && status.font_found) && status.out_free)
               state_in = bblgc_pkg::ST_IDLE;
         end
         default: state_in = bblgc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      op        = bblgc_pkg::OP_NONE;
      req_stall = 1'b1;
      case (state_ff)
         bblgc_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) op = bblgc_pkg::OP_LATCH;
         end
         bblgc_pkg::ST_DECODE: begin
            if (status.out_free) begin
               case (status.req_code)
                  bblgc_pkg::REQ_LOOKUP:
                     op = (status.font_ok && status.hit_found) ? bblgc_pkg::OP_TOUCH
                                                               : bblgc_pkg::OP_MISS;
                  bblgc_pkg::REQ_INSERT: begin
                     if (!status.font_ok) op = bblgc_pkg::OP_MISS;
                     else if (status.hit_found) op = bblgc_pkg::OP_DROP_DUP;
                  end
                  bblgc_pkg::REQ_CLEAR_ALL: op = bblgc_pkg::OP_CLEAR_ALL;
                  default: op = bblgc_pkg::OP_NONE;
               endcase
            end
         end
         bblgc_pkg::ST_EVICT: begin
            if (status.out_free) begin
               if ((!status.free_found || status.over_budget) && status.any_valid)
                  op = bblgc_pkg::OP_DROP_OLD;
               else
                  op = bblgc_pkg::OP_PLACE;
            end
         end
         bblgc_pkg::ST_CLR_FONT: begin
            if (status.font_ok && status.font_found) op = bblgc_pkg::OP_DROP_FONT;
            else if (status.out_free) op = bblgc_pkg::OP_MISS;
         end
         default: op = bblgc_pkg::OP_NONE;
      endcase
   end

endmodule

// ===== sv/bblgc_dpath.sv =====
module bblgc_dpath #(
   parameter int ENTRIES = bblgc_pkg::ENTRIES_DEF,
   parameter int FONTS   = bblgc_pkg::FONTS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bblgc_pkg::dp_op_type                 op,
   output bblgc_pkg::dp_status_type             status,
   input  bblgc_pkg::req_beat_type              req_data,
   input  logic                                 csr_wr_en,
   input  logic [bblgc_pkg::BYTES_W-1:0]        csr_wr_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output bblgc_pkg::rsp_beat_type              rsp_data
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int BW    = bblgc_pkg::BYTES_W;

   bblgc_pkg::req_beat_type req_ff;
   logic [ENTRIES-1:0]                  valid_ff;
   logic [bblgc_pkg::FONT_W-1:0]        font_ff  [ENTRIES];
   logic [bblgc_pkg::CHAR_W-1:0]        char_ff  [ENTRIES];
   logic [bblgc_pkg::SIZE_W-1:0]        bytes_ff [ENTRIES];
   logic [IDX_W-1:0]                    rank_ff  [ENTRIES];
   logic [CNT_W-1:0]                    count_ff;
   logic [BW-1:0]                       total_ff;
   logic [BW-1:0]                       budget_ff;
   logic                                rsp_valid_ff;
   bblgc_pkg::rsp_beat_type             rsp_ff, rsp_in;

   logic [ENTRIES-1:0] hit_vec, font_vec, old_vec;
   logic [IDX_W-1:0]   hit_idx, font_idx, old_idx, free_idx, sel_idx;
   logic               hit_found, font_found, free_found;
   logic [CNT_W-1:0]   cnt_m1;
   logic [IDX_W-1:0]   sel_rank;
   logic [bblgc_pkg::SIZE_W-1:0] sel_bytes;
   logic [BW-1:0]      drop_total, place_total;
   logic [BW:0]        place_sum;
   logic               emit, font_ok, out_free;

   assign cnt_m1 = count_ff - CNT_W'(1);

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         font_vec[i] = valid_ff[i] && (font_ff[i] == req_ff.font_id);
         hit_vec[i]  = font_vec[i] && (char_ff[i] == req_ff.char_code);
         old_vec[i]  = valid_ff[i] && (rank_ff[i] == cnt_m1[IDX_W-1:0]);
      end
   end

   // lowest-numbered match wins
   always_comb begin
      hit_idx = '0; font_idx = '0; old_idx = '0; free_idx = '0;
      hit_found = 1'b0; font_found = 1'b0; free_found = 1'b0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            hit_idx = IDX_W'(i); hit_found = 1'b1;
         end
         if (font_vec[i]) begin
            font_idx = IDX_W'(i); font_found = 1'b1;
         end
         if (old_vec[i]) old_idx = IDX_W'(i);
         if (!valid_ff[i]) begin
            free_idx = IDX_W'(i); free_found = 1'b1;
         end
      end
   end

   always_comb begin
      case (op)
         bblgc_pkg::OP_DROP_OLD:  sel_idx = old_idx;
         bblgc_pkg::OP_DROP_FONT: sel_idx = font_idx;
         bblgc_pkg::OP_PLACE:     sel_idx = free_idx;
         default:                 sel_idx = hit_idx;
      endcase
   end

   assign sel_rank   = rank_ff[sel_idx];
   assign sel_bytes  = bytes_ff[sel_idx];
   assign drop_total = (total_ff >= BW'(sel_bytes)) ? total_ff - BW'(sel_bytes) : '0;
   assign place_sum  = {1'b0, total_ff} + (BW + 1)'(req_ff.item_size);
   assign place_total = place_sum[BW] ? bblgc_pkg::BYTES_MAX : place_sum[BW-1:0];
   assign font_ok    = (32'(req_ff.font_id) < 32'(FONTS));
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      status.req_code    = req_ff.req_type;
      status.out_free    = out_free;
      status.font_ok     = font_ok;
      status.hit_found   = hit_found;
      status.free_found  = free_found;
      status.any_valid   = |valid_ff;
      status.over_budget = place_sum > {1'b0, budget_ff};
      status.font_found  = font_found;
   end

   always_comb begin
      rsp_in            = '0;
      rsp_in.used_bytes = total_ff;
      rsp_in.last       = 1'b1;
      emit              = 1'b1;
      case (op)
         bblgc_pkg::OP_TOUCH: begin
            rsp_in.hit  = 1'b1;
            rsp_in.slot = bblgc_pkg::SLOT_W'(sel_idx);
         end
         bblgc_pkg::OP_DROP_DUP, bblgc_pkg::OP_DROP_OLD: begin
            rsp_in.slot         = bblgc_pkg::SLOT_W'(sel_idx);
            rsp_in.evicted      = 1'b1;
            rsp_in.evicted_font = font_ff[sel_idx];
            rsp_in.evicted_char = char_ff[sel_idx];
            rsp_in.used_bytes   = drop_total;
            rsp_in.last         = 1'b0;
         end
         bblgc_pkg::OP_PLACE: begin
            rsp_in.hit        = 1'b1;
            rsp_in.slot       = bblgc_pkg::SLOT_W'(sel_idx);
            rsp_in.used_bytes = place_total;
         end
         bblgc_pkg::OP_MISS: rsp_in.used_bytes = total_ff;
         bblgc_pkg::OP_CLEAR_ALL: rsp_in.used_bytes = '0;
         default: emit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (op == bblgc_pkg::OP_LATCH) req_ff <= req_data;
      if (emit) rsp_ff <= rsp_in;
      for (int i = 0; i < ENTRIES; i++) begin
         case (op)
            bblgc_pkg::OP_TOUCH: begin
               if (IDX_W'(i) == sel_idx) rank_ff[i] <= '0;
               else if (valid_ff[i] && rank_ff[i] < sel_rank)
                  rank_ff[i] <= rank_ff[i] + IDX_W'(1);
            end
            bblgc_pkg::OP_DROP_DUP, bblgc_pkg::OP_DROP_OLD, bblgc_pkg::OP_DROP_FONT: begin
               if (valid_ff[i] && rank_ff[i] > sel_rank) rank_ff[i] <= rank_ff[i] - IDX_W'(1);
            end
            bblgc_pkg::OP_PLACE: begin
               if (IDX_W'(i) == sel_idx) begin
                  rank_ff[i]  <= '0;
                  font_ff[i]  <= req_ff.font_id;
                  char_ff[i]  <= req_ff.char_code;
                  bytes_ff[i] <= req_ff.item_size;
               end else if (valid_ff[i]) begin
                  rank_ff[i] <= rank_ff[i] + IDX_W'(1);
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         count_ff     <= '0;
         total_ff     <= '0;
         budget_ff    <= bblgc_pkg::BUDGET_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) budget_ff <= csr_wr_data;
         if (emit) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         case (op)
            bblgc_pkg::OP_DROP_DUP, bblgc_pkg::OP_DROP_OLD, bblgc_pkg::OP_DROP_FONT: begin
               valid_ff[sel_idx] <= 1'b0;
               count_ff          <= count_ff - CNT_W'(1);
               total_ff          <= drop_total;
            end
            bblgc_pkg::OP_PLACE: begin
               valid_ff[sel_idx] <= 1'b1;
               count_ff          <= count_ff + CNT_W'(1);
               total_ff          <= place_total;
            end
            bblgc_pkg::OP_CLEAR_ALL: begin
               valid_ff <= '0;
               count_ff <= '0;
               total_ff <= '0;
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== sv/byte_budget_lru_glyph_cache.sv =====
// channel  direction  handshake            beat
// req_     in         req_valid/req_stall  bblgc_pkg::req_beat_type
// rsp_     out        rsp_valid/rsp_stall  bblgc_pkg::rsp_beat_type
// csr_     in         csr_wr_en            byte budget, 22 bits
//
// a request is latched when idle and decoded in the next: lookups and full clears
// answer from decode; an insert drops least-recent entries and places (a replaced
// copy of the same key is dropped in the decode cycle), a font clear drops its
// entries, then answers; one entry per cycle, evictions only while output is free
// reset is synchronous and empties the cache with no sweep
// a stalled result holds the controller until the output register frees
module byte_budget_lru_glyph_cache #(
   parameter int ENTRIES = bblgc_pkg::ENTRIES_DEF,
   parameter int FONTS   = bblgc_pkg::FONTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  bblgc_pkg::req_beat_type       req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output bblgc_pkg::rsp_beat_type       rsp_data,
   input  logic                          csr_wr_en,
   input  logic [bblgc_pkg::BYTES_W-1:0] csr_wr_data
);

   bblgc_pkg::dp_op_type     op;
   bblgc_pkg::dp_status_type status;

   bblgc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .op        (op)
   );

   bblgc_dpath #(
      .ENTRIES (ENTRIES),
      .FONTS   (FONTS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .op          (op),
      .status      (status),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

// ===== bench/byte_budget_lru_glyph_cache_tb.sv =====
module byte_budget_lru_glyph_cache_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSLOT = 32;
   localparam int CYCLE_LIMIT = 3000000;

   typedef struct {
      bblgc_pkg::req_beat_type beat;
      bit                      typed;
      bblgc_pkg::rsp_beat_type res;
   } dir_row_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   bblgc_pkg::req_beat_type       req_data;
   logic                          rsp_valid;
   logic                          rsp_stall;
   bblgc_pkg::rsp_beat_type       rsp_data;
   logic                          csr_wr_en;
   logic [bblgc_pkg::BYTES_W-1:0] csr_wr_data;

   // shadow of the cache contents
   bit          shadow_valid [NSLOT];
   int unsigned shadow_font  [NSLOT];
   int unsigned shadow_char  [NSLOT];
   int unsigned shadow_bytes [NSLOT];
   int unsigned shadow_rank  [NSLOT];
   int unsigned shadow_total;
   int unsigned shadow_budget;

   bblgc_pkg::rsp_beat_type pending_rsp_q[$];
   dir_row_type             dir_rows[$];

   int unsigned cycle_count;
   int unsigned fail_count;
   int unsigned items_sent;
   int unsigned beats_seen;
   int unsigned evict_seen;
   int unsigned hit_seen;
   int unsigned tx_idle_pct;
   int unsigned rx_stall_pct;

   byte_budget_lru_glyph_cache i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic bblgc_pkg::req_beat_type mk_req(logic [1:0] t, int unsigned f,
                                                      int unsigned c, int unsigned s);
      bblgc_pkg::req_beat_type b;
      b.req_type  = t;
      b.font_id   = bblgc_pkg::FONT_W'(f);
      b.char_code = bblgc_pkg::CHAR_W'(c);
      b.item_size = bblgc_pkg::SIZE_W'(s);
      return b;
   endfunction

   function automatic bblgc_pkg::rsp_beat_type mk_rsp(bit h, int unsigned sl, bit ev,
                                                      int unsigned f, int unsigned c,
                                                      int unsigned used, bit lst);
      bblgc_pkg::rsp_beat_type r;
      r.hit          = h;
      r.slot         = bblgc_pkg::SLOT_W'(sl);
      r.evicted      = ev;
      r.evicted_font = bblgc_pkg::FONT_W'(f);
      r.evicted_char = bblgc_pkg::CHAR_W'(c);
      r.used_bytes   = bblgc_pkg::BYTES_W'(used);
      r.last         = lst;
      return r;
   endfunction

   function automatic void shadow_drop(int e);
      int unsigned r;
      r = shadow_rank[e];
      shadow_valid[e] = 1'b0;
      for (int i = 0; i < NSLOT; i++)
         if (shadow_valid[i] && shadow_rank[i] > r) shadow_rank[i]--;
      shadow_total = (shadow_total >= shadow_bytes[e]) ? shadow_total - shadow_bytes[e] : 0;
   endfunction

   function automatic int shadow_find(int unsigned f, int unsigned c);
      for (int i = 0; i < NSLOT; i++)
         if (shadow_valid[i] && shadow_font[i] == f && shadow_char[i] == c) return i;
      return -1;
   endfunction

   function automatic int lowest_free();
      for (int i = 0; i < NSLOT; i++)
         if (!shadow_valid[i]) return i;
      return -1;
   endfunction

   function automatic int least_recent();
      int best;
      best = -1;
      for (int i = 0; i < NSLOT; i++)
         if (shadow_valid[i] && (best < 0 || shadow_rank[i] > shadow_rank[best])) best = i;
      return best;
   endfunction

   function automatic void push_evict(int e);
      pending_rsp_q.push_back(mk_rsp(0, e, 1, shadow_font[e], shadow_char[e],
                                     shadow_total, 0));
   endfunction

   // work out every result beat one request causes and queue them
   function automatic void predict_request(bblgc_pkg::req_beat_type b);
      int unsigned f, c, sz, r;
      int e, v;
      f  = b.font_id;
      c  = b.char_code;
      sz = b.item_size;
      case (b.req_type)
         bblgc_pkg::REQ_LOOKUP: begin
            e = shadow_find(f, c);
            if (e >= 0) begin
               r = shadow_rank[e];
               for (int i = 0; i < NSLOT; i++)
                  if (shadow_valid[i] && i != e && shadow_rank[i] < r) shadow_rank[i]++;
               shadow_rank[e] = 0;
               pending_rsp_q.push_back(mk_rsp(1, e, 0, 0, 0, shadow_total, 1));
            end else begin
               pending_rsp_q.push_back(mk_rsp(0, 0, 0, 0, 0, shadow_total, 1));
            end
         end
         bblgc_pkg::REQ_INSERT: begin
            e = shadow_find(f, c);
            if (e >= 0) begin
               shadow_drop(e);
               push_evict(e);
            end
            e = lowest_free();
            while (e < 0 || shadow_total + sz > shadow_budget) begin
               v = least_recent();
               if (v < 0) break;
               shadow_drop(v);
               push_evict(v);
               e = lowest_free();
            end
            if (e < 0) e = 0;
            for (int i = 0; i < NSLOT; i++)
               if (shadow_valid[i]) shadow_rank[i]++;
            shadow_valid[e] = 1'b1;
            shadow_font[e]  = f;
            shadow_char[e]  = c;
            shadow_bytes[e] = sz;
            shadow_rank[e]  = 0;
            shadow_total = (shadow_total + sz > bblgc_pkg::BYTES_MAX) ? bblgc_pkg::BYTES_MAX
                                                                     : shadow_total + sz;
            pending_rsp_q.push_back(mk_rsp(1, e, 0, 0, 0, shadow_total, 1));
         end
         bblgc_pkg::REQ_CLEAR_FNT: begin
            for (int i = 0; i < NSLOT; i++)
               if (shadow_valid[i] && shadow_font[i] == f) shadow_drop(i);
            pending_rsp_q.push_back(mk_rsp(0, 0, 0, 0, 0, shadow_total, 1));
         end
         default: begin
            for (int i = 0; i < NSLOT; i++) shadow_valid[i] = 1'b0;
            shadow_total = 0;
            pending_rsp_q.push_back(mk_rsp(0, 0, 0, 0, 0, shadow_total, 1));
         end
      endcase
   endfunction

   function automatic void field_check(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
         fail_count++;
      end
   endfunction

   // result side: compare each accepted beat with the oldest expectation
   always @(posedge clock) begin
      bblgc_pkg::rsp_beat_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_seen++;
         if (pending_rsp_q.size() == 0) begin
            $display("%0t: unexpected result beat, actual %h", $time, rsp_data);
            fail_count++;
         end else begin
            exp_r = pending_rsp_q.pop_front();
            field_check("hit", exp_r.hit, rsp_data.hit);
            field_check("slot", exp_r.slot, rsp_data.slot);
            field_check("evicted", exp_r.evicted, rsp_data.evicted);
            field_check("evicted_font", exp_r.evicted_font, rsp_data.evicted_font);
            field_check("evicted_char", exp_r.evicted_char, rsp_data.evicted_char);
            field_check("used_bytes", exp_r.used_bytes, rsp_data.used_bytes);
            field_check("last", exp_r.last, rsp_data.last);
            if (exp_r.evicted) evict_seen++;
            if (exp_r.hit && exp_r.last) hit_seen++;
         end
      end
   end

   always @(posedge clock) begin
      rsp_stall <= (rx_stall_pct != 0) && ($urandom_range(99) < rx_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("byte_budget_lru_glyph_cache_tb NOT OK");
         $finish;
      end
   end

   task automatic send_beat(bblgc_pkg::req_beat_type b);
      while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= b;
      do @(posedge clock); while (req_stall);
      predict_request(b);
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      // quiet spell before a register write
      repeat (40) @(posedge clock);
   endtask

   task automatic write_budget(int unsigned value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= bblgc_pkg::BYTES_W'(value);
      @(posedge clock);
      shadow_budget = value & bblgc_pkg::BYTES_MAX;
      csr_wr_en   <= 1'b0;
   endtask

   function automatic bblgc_pkg::req_beat_type random_req();
      int unsigned pick, f, c, s, cap;
      pick = $urandom_range(99);
      f = (pick < 90) ? $urandom_range(3) : $urandom_range(15);
      c = ($urandom_range(9) < 8) ? $urandom_range(40) : $urandom_range(65535);
      cap = shadow_budget / 6 + 1;
      if (cap > 131071) cap = 131071;
      s = ($urandom_range(9) < 8) ? $urandom_range(cap) : $urandom_range(131071);
      if (pick < 50) return mk_req(bblgc_pkg::REQ_INSERT, f, c, s);
      if (pick < 85) return mk_req(bblgc_pkg::REQ_LOOKUP, f, c, s);
      if (pick < 93) return mk_req(bblgc_pkg::REQ_CLEAR_FNT, f, c, s);
      if (pick < 95) return mk_req(bblgc_pkg::REQ_CLEAR_ALL, f, c, s);
      return mk_req(2'($urandom_range(3)), $urandom_range(15), $urandom_range(65535),
                    $urandom_range(131071));
   endfunction

   initial begin
      int unsigned budgets[5];
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_data     <= '0;
      rsp_stall    <= 1'b0;
      csr_wr_en    <= 1'b0;
      csr_wr_data  <= '0;
      cycle_count  = 0;
      fail_count   = 0;
      items_sent   = 0;
      beats_seen   = 0;
      evict_seen   = 0;
      hit_seen     = 0;
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      shadow_total = 0;
      shadow_budget = bblgc_pkg::BUDGET_RESET;
      for (int i = 0; i < NSLOT; i++) shadow_valid[i] = 1'b0;

      dir_rows.push_back('{mk_req(bblgc_pkg::REQ_LOOKUP, 0, 0, 0), 1,
                           mk_rsp(0, 0, 0, 0, 0, 0, 1)});
      dir_rows.push_back('{mk_req(bblgc_pkg::REQ_CLEAR_ALL, 0, 0, 0), 1,
                           mk_rsp(0, 0, 0, 0, 0, 0, 1)});
      dir_rows.push_back('{mk_req(bblgc_pkg::REQ_CLEAR_FNT, 15, 0, 0), 1,
                           mk_rsp(0, 0, 0, 0, 0, 0, 1)});
      dir_rows.push_back('{mk_req(bblgc_pkg::REQ_INSERT, 15, 65535, 0), 1,
                           mk_rsp(1, 0, 0, 0, 0, 0, 1)});
      dir_rows.push_back('{mk_req(bblgc_pkg::REQ_INSERT, 0, 0, 65536), 1,
                           mk_rsp(1, 1, 0, 0, 0, 65536, 1)});
      dir_rows.push_back('{mk_req(bblgc_pkg::REQ_LOOKUP, 15, 65535, 131071), 1,
                           mk_rsp(1, 0, 0, 0, 0, 65536, 1)});
      // re-insert of a present key reports the old copy first
      dir_rows.push_back('{mk_req(bblgc_pkg::REQ_INSERT, 0, 0, 1), 0, '0});
      // larger than the budget: everything goes, item still placed
      dir_rows.push_back('{mk_req(bblgc_pkg::REQ_INSERT, 3, 5, 131071), 0, '0});
      dir_rows.push_back('{mk_req(bblgc_pkg::REQ_LOOKUP, 0, 0, 0), 1,
                           mk_rsp(0, 0, 0, 0, 0, 131071, 1)});
      dir_rows.push_back('{mk_req(bblgc_pkg::REQ_CLEAR_FNT, 3, 0, 0), 1,
                           mk_rsp(0, 0, 0, 0, 0, 0, 1)});
      for (int k = 1; k <= 4; k++)
         dir_rows.push_back('{mk_req(bblgc_pkg::REQ_INSERT, 1, k, 100), 0, '0});
      dir_rows.push_back('{mk_req(bblgc_pkg::REQ_LOOKUP, 1, 1, 0), 0, '0});
      dir_rows.push_back('{mk_req(bblgc_pkg::REQ_LOOKUP, 1, 4, 0), 0, '0});
      dir_rows.push_back('{mk_req(bblgc_pkg::REQ_INSERT, 2, 9, 65400), 0, '0});
      dir_rows.push_back('{mk_req(bblgc_pkg::REQ_INSERT, 2, 9, 0), 0, '0});
      dir_rows.push_back('{mk_req(bblgc_pkg::REQ_CLEAR_FNT, 1, 0, 0), 0, '0});
      dir_rows.push_back('{mk_req(bblgc_pkg::REQ_CLEAR_ALL, 7, 1234, 999), 1,
                           mk_rsp(0, 0, 0, 0, 0, 0, 1)});

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[k]) begin
         send_beat(dir_rows[k].beat);
         if (dir_rows[k].typed) begin
            void'(pending_rsp_q.pop_back());
            pending_rsp_q.push_back(dir_rows[k].res);
         end
      end

      // zero budget: every insert flushes the cache
      write_budget(0);
      for (int k = 0; k < 4; k++) send_beat(mk_req(bblgc_pkg::REQ_INSERT, k, k, k * 10));

      budgets = '{1, 4194303, 4096, 300000, 65536};
      for (int p = 0; p < 5; p++) begin
         write_budget(budgets[p]);
         case (p % 4)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 82; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 82; end
            default: begin tx_idle_pct = 34; rx_stall_pct = 34; end
         endcase
         for (int k = 0; k < 85; k++) send_beat(random_req());
         // make the cache spill on slot count with small entries
         if (budgets[p] == 4194303)
            for (int k = 0; k < 40; k++)
               send_beat(mk_req(bblgc_pkg::REQ_INSERT, 5, 100 + k, 7));
      end

      drain();
      $display("%0d requests, %0d result beats, %0d evictions, %0d hits/placements",
               items_sent, beats_seen, evict_seen, hit_seen);
      $display("budgets from zero to full scale under mixed idle and stall patterns");
      if (fail_count == 0)
         $display("byte_budget_lru_glyph_cache_tb OK");
      else
         $display("byte_budget_lru_glyph_cache_tb NOT OK");
      $finish;
   end

endmodule
